// ----- hdl/tlsqba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsqba_pkg
// shared types, codes and sizes of the two-lane send queue burst arbiter
// ----------------------------------------------------------------------------
package tlsqba_pkg;

    // lane sizes
    localparam int NORMAL_DEPTH  = 256;
    localparam int CONTROL_DEPTH = 64;

    localparam int NORMAL_AW  = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int CONTROL_AW = (CONTROL_DEPTH > 1) ? $clog2(CONTROL_DEPTH) : 1;
    localparam int NORMAL_FW  = $clog2(NORMAL_DEPTH + 1);
    localparam int CONTROL_FW = $clog2(CONTROL_DEPTH + 1);
    localparam int CANCEL_W   = ((NORMAL_FW > CONTROL_FW) ? NORMAL_FW : CONTROL_FW) + 1;
    localparam int DOWN_W     = (CANCEL_W > 16) ? CANCEL_W : 16;

    // field widths
    localparam int HANDLE_W   = 16;
    localparam int INFLIGHT_W = 16;
    localparam int BURST_W    = 4;

    localparam logic [7:0]         MAX_DEST_LEN = 8'd128;
    localparam logic [BURST_W-1:0] BURST_MAX    = 4'd15;
    localparam logic [BURST_W-1:0] BURST_RESET  = 4'd4;
    localparam logic [1:0]         PRIO_NORMAL  = 2'd0;
    localparam logic [1:0]         PRIO_CONTROL = 2'd1;

    typedef enum logic [1:0] {
        CMD_SUBMIT   = 2'd0,
        CMD_DRAIN    = 2'd1,
        CMD_CANCEL   = 2'd2,
        CMD_COMPLETE = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        RES_SENT      = 3'd0,
        RES_QUEUED    = 3'd1,
        RES_FULL      = 3'd2,
        RES_INVALID   = 3'd3,
        RES_DRAINED   = 3'd4,
        RES_EMPTY     = 3'd5,
        RES_CANCELED  = 3'd6,
        RES_COMPLETED = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic emit;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } ctl_stat_t;

endpackage

// ----- hdl/tlsqba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsqba_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module tlsqba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                            aclk,
    input  logic                                            we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
    input  logic [WIDTH-1:0]                                wdata,
    input  logic                                            re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
    output logic [WIDTH-1:0]                                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tlsqba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsqba_ctrl
// request sequencer: capture, execute, emit
// ----------------------------------------------------------------------------
module tlsqba_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output tlsqba_pkg::ctl_cmd_t   cmd,
    input  tlsqba_pkg::ctl_stat_t  stat
);

    tlsqba_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlsqba_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.emit    = 1'b0;
        unique case (state_reg)
            tlsqba_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = tlsqba_pkg::S_EXEC;
                end
            end
            tlsqba_pkg::S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = tlsqba_pkg::S_EMIT;
            end
            tlsqba_pkg::S_EMIT: begin
                // wait for the output register to be free
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = tlsqba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tlsqba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tlsqba_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsqba_dp
// lane rings, arbiter state, counters and the result register
// ----------------------------------------------------------------------------
module tlsqba_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tlsqba_pkg::ctl_cmd_t   cmd,
    output tlsqba_pkg::ctl_stat_t  stat,
    input  logic                   cfg_we,
    input  logic [3:0]             cfg_wdata,
    input  logic [1:0]             s_command,
    input  logic                   s_slot_free,
    input  logic [1:0]             s_priority_req,
    input  logic [15:0]            s_packet_handle,
    input  logic [7:0]             s_dest_length,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [15:0]            m_out_handle,
    output logic                   m_out_from_control,
    output logic                   m_fairness_yield,
    output logic [8:0]             m_canceled_count,
    output logic [15:0]            m_outstanding_count,
    output logic [6:0]             m_control_depth,
    output logic [8:0]             m_normal_depth
);

    localparam int NAW = tlsqba_pkg::NORMAL_AW;
    localparam int CAW = tlsqba_pkg::CONTROL_AW;
    localparam int NFW = tlsqba_pkg::NORMAL_FW;
    localparam int CFW = tlsqba_pkg::CONTROL_FW;
    localparam int NSW = NFW + 1;
    localparam int CSW = CFW + 1;
    localparam int KW  = tlsqba_pkg::CANCEL_W;
    localparam int DW  = tlsqba_pkg::DOWN_W;
    localparam int HW  = tlsqba_pkg::HANDLE_W;
    localparam int IW  = tlsqba_pkg::INFLIGHT_W;
    localparam int BW  = tlsqba_pkg::BURST_W;

    // captured request
    tlsqba_pkg::command_t cmd_reg;
    logic                 slot_reg;
    logic [1:0]           prio_reg;
    logic [HW-1:0]        handle_reg;
    logic [7:0]           dlen_reg;

    // queue and arbiter state
    logic [NAW-1:0] nhead_reg, nhead_next;
    logic [NFW-1:0] nfill_reg, nfill_next;
    logic [CAW-1:0] chead_reg, chead_next;
    logic [CFW-1:0] cfill_reg, cfill_next;
    logic [BW-1:0]  burst_reg, burst_next;
    logic [IW-1:0]  inflight_reg, inflight_next;
    logic [BW-1:0]  cburst_reg;

    // pending result
    tlsqba_pkg::status_t pst_reg, pst_next;
    logic [HW-1:0]       phandle_reg, phandle_next;
    logic                pctl_reg, pctl_next;
    logic                pyield_reg, pyield_next;
    logic [KW-1:0]       pcancel_reg, pcancel_next;
    logic                ppopn_reg, ppopn_next;
    logic                ppopc_reg, ppopc_next;

    // output register
    logic                m_valid_reg;
    tlsqba_pkg::status_t ostatus_reg;
    logic [HW-1:0]       ohandle_reg;
    logic                octl_reg;
    logic                oyield_reg;
    logic [8:0]          ocancel_reg;
    logic [15:0]         oinflight_reg;
    logic [6:0]          ocdepth_reg;
    logic [8:0]          ondepth_reg;

    // ring addressing
    logic [NSW-1:0] n_sum;
    logic [CSW-1:0] c_sum;
    logic [NAW-1:0] n_tail, n_inc;
    logic [CAW-1:0] c_tail, c_inc;
    logic           n_full, c_full, sub_bad, pick_c, pick_n;
    logic [KW-1:0]  total;
    logic [DW-1:0]  dec_amt;
    logic [DW-1:0]  infl_ext;
    logic [IW-1:0]  infl_up, infl_down;

    // ram ports
    logic           n_we, n_re, c_we, c_re;
    logic [HW-1:0]  n_rdata, c_rdata;

    assign n_sum  = NSW'(nhead_reg) + NSW'(nfill_reg);
    assign c_sum  = CSW'(chead_reg) + CSW'(cfill_reg);
    assign n_tail = (n_sum >= NSW'(tlsqba_pkg::NORMAL_DEPTH))
                    ? NAW'(n_sum - NSW'(tlsqba_pkg::NORMAL_DEPTH)) : NAW'(n_sum);
    assign c_tail = (c_sum >= CSW'(tlsqba_pkg::CONTROL_DEPTH))
                    ? CAW'(c_sum - CSW'(tlsqba_pkg::CONTROL_DEPTH)) : CAW'(c_sum);
    assign n_inc  = (nhead_reg == NAW'(tlsqba_pkg::NORMAL_DEPTH - 1))
                    ? '0 : NAW'(nhead_reg + 1'b1);
    assign c_inc  = (chead_reg == CAW'(tlsqba_pkg::CONTROL_DEPTH - 1))
                    ? '0 : CAW'(chead_reg + 1'b1);
    assign n_full = (nfill_reg == NFW'(tlsqba_pkg::NORMAL_DEPTH));
    assign c_full = (cfill_reg == CFW'(tlsqba_pkg::CONTROL_DEPTH));

    assign sub_bad = (prio_reg != tlsqba_pkg::PRIO_NORMAL && prio_reg != tlsqba_pkg::PRIO_CONTROL)
                     || (dlen_reg == 8'd0) || (dlen_reg > tlsqba_pkg::MAX_DEST_LEN);

    // control wins until its burst is used up while normal waits
    assign pick_c = (cfill_reg != '0) && ((nfill_reg == '0) || (burst_reg < cburst_reg));
    assign pick_n = !pick_c && (nfill_reg != '0);

    assign total    = KW'(cfill_reg) + KW'(nfill_reg);
    assign dec_amt  = (cmd_reg == tlsqba_pkg::CMD_CANCEL) ? DW'(total) : DW'(1);
    assign infl_ext = DW'(inflight_reg);
    assign infl_down = (infl_ext > dec_amt) ? IW'(infl_ext - dec_amt) : '0;
    assign infl_up   = (inflight_reg == '1) ? inflight_reg : IW'(inflight_reg + 1'b1);

    always_comb begin
        nhead_next    = nhead_reg;
        nfill_next    = nfill_reg;
        chead_next    = chead_reg;
        cfill_next    = cfill_reg;
        burst_next    = burst_reg;
        inflight_next = inflight_reg;
        pst_next      = pst_reg;
        phandle_next  = phandle_reg;
        pctl_next     = pctl_reg;
        pyield_next   = pyield_reg;
        pcancel_next  = pcancel_reg;
        ppopn_next    = ppopn_reg;
        ppopc_next    = ppopc_reg;
        n_we          = 1'b0;
        c_we          = 1'b0;
        n_re          = 1'b0;
        c_re          = 1'b0;
        if (cmd.exec) begin
            phandle_next = '0;
            pctl_next    = 1'b0;
            pyield_next  = 1'b0;
            pcancel_next = '0;
            ppopn_next   = 1'b0;
            ppopc_next   = 1'b0;
            unique case (cmd_reg)
                tlsqba_pkg::CMD_SUBMIT: begin
                    if (sub_bad) begin
                        pst_next = tlsqba_pkg::RES_INVALID;
                    end else if (slot_reg) begin
                        pst_next      = tlsqba_pkg::RES_SENT;
                        phandle_next  = handle_reg;
                        pctl_next     = prio_reg[0];
                        inflight_next = infl_up;
                    end else if (prio_reg == tlsqba_pkg::PRIO_CONTROL) begin
                        if (c_full) begin
                            pst_next = tlsqba_pkg::RES_FULL;
                        end else begin
                            c_we          = 1'b1;
                            cfill_next    = CFW'(cfill_reg + 1'b1);
                            inflight_next = infl_up;
                            pst_next      = tlsqba_pkg::RES_QUEUED;
                        end
                    end else begin
                        if (n_full) begin
                            pst_next = tlsqba_pkg::RES_FULL;
                        end else begin
                            n_we          = 1'b1;
                            nfill_next    = NFW'(nfill_reg + 1'b1);
                            inflight_next = infl_up;
                            pst_next      = tlsqba_pkg::RES_QUEUED;
                        end
                    end
                end
                tlsqba_pkg::CMD_DRAIN: begin
                    if (pick_c) begin
                        c_re       = 1'b1;
                        ppopc_next = 1'b1;
                        pctl_next  = 1'b1;
                        chead_next = c_inc;
                        cfill_next = CFW'(cfill_reg - 1'b1);
                        if (burst_reg < tlsqba_pkg::BURST_MAX) begin
                            burst_next = BW'(burst_reg + 1'b1);
                        end
                        pst_next = tlsqba_pkg::RES_DRAINED;
                    end else if (pick_n) begin
                        n_re        = 1'b1;
                        ppopn_next  = 1'b1;
                        pyield_next = (cfill_reg != '0) && (burst_reg >= cburst_reg);
                        nhead_next  = n_inc;
                        nfill_next  = NFW'(nfill_reg - 1'b1);
                        burst_next  = '0;
                        pst_next    = tlsqba_pkg::RES_DRAINED;
                    end else begin
                        pst_next = tlsqba_pkg::RES_EMPTY;
                    end
                end
                tlsqba_pkg::CMD_CANCEL: begin
                    pcancel_next  = total;
                    inflight_next = infl_down;
                    chead_next    = c_tail;
                    nhead_next    = n_tail;
                    cfill_next    = '0;
                    nfill_next    = '0;
                    pst_next      = tlsqba_pkg::RES_CANCELED;
                end
                tlsqba_pkg::CMD_COMPLETE: begin
                    inflight_next = infl_down;
                    pst_next      = tlsqba_pkg::RES_COMPLETED;
                end
                default: begin
                    pst_next = tlsqba_pkg::RES_INVALID;
                end
            endcase
        end
    end

    tlsqba_ram #(.WIDTH(HW), .DEPTH(tlsqba_pkg::NORMAL_DEPTH)) u_nram (
        .aclk  (aclk),
        .we    (n_we),
        .waddr (n_tail),
        .wdata (handle_reg),
        .re    (n_re),
        .raddr (nhead_reg),
        .rdata (n_rdata)
    );

    tlsqba_ram #(.WIDTH(HW), .DEPTH(tlsqba_pkg::CONTROL_DEPTH)) u_cram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_tail),
        .wdata (handle_reg),
        .re    (c_re),
        .raddr (chead_reg),
        .rdata (c_rdata)
    );

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg    <= tlsqba_pkg::command_t'(s_command);
            slot_reg   <= s_slot_free;
            prio_reg   <= s_priority_req;
            handle_reg <= s_packet_handle;
            dlen_reg   <= s_dest_length;
        end
    end

    // pending result payload
    always_ff @(posedge aclk) begin
        pst_reg     <= pst_next;
        phandle_reg <= phandle_next;
        pctl_reg    <= pctl_next;
        pyield_reg  <= pyield_next;
        pcancel_reg <= pcancel_next;
        ppopn_reg   <= ppopn_next;
        ppopc_reg   <= ppopc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nhead_reg    <= '0;
            nfill_reg    <= '0;
            chead_reg    <= '0;
            cfill_reg    <= '0;
            burst_reg    <= '0;
            inflight_reg <= '0;
            cburst_reg   <= tlsqba_pkg::BURST_RESET;
        end else begin
            nhead_reg    <= nhead_next;
            nfill_reg    <= nfill_next;
            chead_reg    <= chead_next;
            cfill_reg    <= cfill_next;
            burst_reg    <= burst_next;
            inflight_reg <= inflight_next;
            if (cfg_we) begin
                cburst_reg <= cfg_wdata;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            ostatus_reg   <= pst_reg;
            ohandle_reg   <= ppopc_reg ? c_rdata : (ppopn_reg ? n_rdata : phandle_reg);
            octl_reg      <= pctl_reg;
            oyield_reg    <= pyield_reg;
            ocancel_reg   <= 9'(pcancel_reg);
            oinflight_reg <= 16'(inflight_reg);
            ocdepth_reg   <= 7'(cfill_reg);
            ondepth_reg   <= 9'(nfill_reg);
        end
    end

    assign stat.out_free       = !m_valid_reg || m_ready;
    assign m_valid             = m_valid_reg;
    assign m_status            = ostatus_reg;
    assign m_out_handle        = ohandle_reg;
    assign m_out_from_control  = octl_reg;
    assign m_fairness_yield    = oyield_reg;
    assign m_canceled_count    = ocancel_reg;
    assign m_outstanding_count = oinflight_reg;
    assign m_control_depth     = ocdepth_reg;
    assign m_normal_depth      = ondepth_reg;

endmodule

// ----- hdl/two_lane_send_queue_burst_arbiter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_lane_send_queue_burst_arbiter_unit
// two send-handle lanes (control, normal) with a burst-limited drain arbiter
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_valid / s_ready    command, slot, priority, handle, length
//  m_*       out        m_valid / m_ready    status, handle, lane, yield, counts
//  cfg_*     in         cfg_we (no wait)     control burst limit, 4 bits
//
//  each request passes through capture, execute and emit; the sequencer
//  handles one request at a time and the drain path needs the emit step
//  for the registered ram read of the lane head
//  a finished result sits in the output register, so the next request is
//  taken while it waits; a stalled m_ready holds the sequencer in emit
//  aresetn is synchronous, active low; lane rings need no clearing pass
// ----------------------------------------------------------------------------
module two_lane_send_queue_burst_arbiter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // burst limit register
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic        s_slot_free,
    input  logic [1:0]  s_priority_req,
    input  logic [15:0] s_packet_handle,
    input  logic [7:0]  s_dest_length,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_out_handle,
    output logic        m_out_from_control,
    output logic        m_fairness_yield,
    output logic [8:0]  m_canceled_count,
    output logic [15:0] m_outstanding_count,
    output logic [6:0]  m_control_depth,
    output logic [8:0]  m_normal_depth
);

    // command and status between sequencer and datapath
    tlsqba_pkg::ctl_cmd_t  cmd;
    tlsqba_pkg::ctl_stat_t stat;

    // sequencer: idle -> execute -> emit
    tlsqba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // lanes, arbiter, counters and result register
    tlsqba_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_command           (s_command),
        .s_slot_free         (s_slot_free),
        .s_priority_req      (s_priority_req),
        .s_packet_handle     (s_packet_handle),
        .s_dest_length       (s_dest_length),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_out_handle        (m_out_handle),
        .m_out_from_control  (m_out_from_control),
        .m_fairness_yield    (m_fairness_yield),
        .m_canceled_count    (m_canceled_count),
        .m_outstanding_count (m_outstanding_count),
        .m_control_depth     (m_control_depth),
        .m_normal_depth      (m_normal_depth)
    );

endmodule

// ----- hdl/tlsqba_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsqba_chk
// port-level checks on the result channel of the send queue arbiter
// ----------------------------------------------------------------------------
module tlsqba_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [15:0] m_out_handle,
    input  logic        m_out_from_control,
    input  logic        m_fairness_yield,
    input  logic [8:0]  m_canceled_count,
    input  logic [6:0]  m_control_depth,
    input  logic [8:0]  m_normal_depth
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_handle))
        else $error("result changed while stalled");

    // an empty drain means both lanes are empty
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == tlsqba_pkg::RES_EMPTY
        |-> m_control_depth == 7'd0 && m_normal_depth == 9'd0)
        else $error("empty drain with queued entries");

    // cancel leaves both lanes empty
    a_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == tlsqba_pkg::RES_CANCELED
        |-> m_control_depth == 7'd0 && m_normal_depth == 9'd0)
        else $error("lanes not empty after cancel");

    // a yield is a normal-lane drain
    a_yield: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fairness_yield
        |-> m_status == tlsqba_pkg::RES_DRAINED && !m_out_from_control
            && m_canceled_count == 9'd0)
        else $error("yield on a request that is not a normal drain");

endmodule

bind two_lane_send_queue_burst_arbiter_unit tlsqba_chk u_tlsqba_chk (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_status           (m_status),
    .m_out_handle       (m_out_handle),
    .m_out_from_control (m_out_from_control),
    .m_fairness_yield   (m_fairness_yield),
    .m_canceled_count   (m_canceled_count),
    .m_control_depth    (m_control_depth),
    .m_normal_depth     (m_normal_depth)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the two-lane send queue burst arbiter
//
// requests go in over the s_ channel and results come back over m_; a shadow
// of both handle rings, the burst counter and the outstanding count works out
// each result as its request is taken, and every result on m_ is compared with
// the oldest one still due. a directed opening is followed by lane fill-ups,
// a full cancel, a burst/yield run and random phases under several burst
// limits, with random gaps on both sides of the block
// ----------------------------------------------------------------------------
module tb;
    import tlsqba_pkg::*;

    // priority codes the block must reject
    localparam logic [1:0] PRIO_BAD_LO = 2'd2;
    localparam logic [1:0] PRIO_BAD_HI = 2'd3;

    typedef struct packed {
        status_t     status;
        logic [15:0] handle;
        logic        from_ctl;
        logic        yield_flag;
        logic [8:0]  canceled;
        logic [15:0] outstanding;
        logic [6:0]  ctl_depth;
        logic [8:0]  nrm_depth;
    } send_result_t;

    // shadow of the lanes and arbiter, plus the results still due
    class arbiter_shadow;
        logic [15:0]  normal_ring [NORMAL_DEPTH];
        logic [15:0]  control_ring [CONTROL_DEPTH];
        int unsigned  normal_rd, normal_cnt, control_rd, control_cnt;
        logic [3:0]   burst_limit, burst_count;
        logic [15:0]  in_flight;
        send_result_t due_results [$];
        int           errors;

        function new();
            burst_limit = BURST_RESET;
            burst_count = '0;
            in_flight   = '0;
            normal_rd   = 0;
            normal_cnt  = 0;
            control_rd  = 0;
            control_cnt = 0;
            errors      = 0;
        endfunction

        function void write_burst(logic [3:0] value);
            burst_limit = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void count_up();
            if (in_flight != '1) in_flight++;
        endfunction

        // work out the result of one accepted request
        function void note_request(command_t cmd, logic slot, logic [1:0] prio,
                                   logic [15:0] handle, logic [7:0] dlen);
            send_result_t r;
            int unsigned  removed;
            r = '0;
            case (cmd)
                CMD_SUBMIT: begin
                    if (prio != PRIO_NORMAL && prio != PRIO_CONTROL ||
                        dlen == 0 || dlen > MAX_DEST_LEN) begin
                        r.status = RES_INVALID;
                    end else if (slot) begin
                        r.status   = RES_SENT;
                        r.handle   = handle;
                        r.from_ctl = (prio == PRIO_CONTROL);
                        count_up();
                    end else if (prio == PRIO_CONTROL) begin
                        if (control_cnt >= CONTROL_DEPTH) begin
                            r.status = RES_FULL;
                        end else begin
                            control_ring[(control_rd + control_cnt) % CONTROL_DEPTH] = handle;
                            control_cnt++;
                            count_up();
                            r.status = RES_QUEUED;
                        end
                    end else begin
                        if (normal_cnt >= NORMAL_DEPTH) begin
                            r.status = RES_FULL;
                        end else begin
                            normal_ring[(normal_rd + normal_cnt) % NORMAL_DEPTH] = handle;
                            normal_cnt++;
                            count_up();
                            r.status = RES_QUEUED;
                        end
                    end
                end
                CMD_DRAIN: begin
                    if (control_cnt != 0 && (normal_cnt == 0 || burst_count < burst_limit)) begin
                        r.handle   = control_ring[control_rd];
                        r.from_ctl = 1'b1;
                        control_rd = (control_rd + 1) % CONTROL_DEPTH;
                        control_cnt--;
                        if (burst_count != BURST_MAX) burst_count++;
                        r.status = RES_DRAINED;
                    end else if (normal_cnt != 0) begin
                        r.yield_flag = (control_cnt != 0 && burst_count >= burst_limit);
                        r.handle     = normal_ring[normal_rd];
                        normal_rd    = (normal_rd + 1) % NORMAL_DEPTH;
                        normal_cnt--;
                        burst_count  = '0;
                        r.status     = RES_DRAINED;
                    end else begin
                        r.status = RES_EMPTY;
                    end
                end
                CMD_CANCEL: begin
                    removed    = control_cnt + normal_cnt;
                    r.canceled = removed[8:0];
                    if (in_flight > removed) in_flight = in_flight - removed[15:0];
                    else in_flight = '0;
                    control_rd  = (control_rd + control_cnt) % CONTROL_DEPTH;
                    normal_rd   = (normal_rd + normal_cnt) % NORMAL_DEPTH;
                    control_cnt = 0;
                    normal_cnt  = 0;
                    r.status    = RES_CANCELED;
                end
                default: begin
                    if (in_flight != '0) in_flight--;
                    r.status = RES_COMPLETED;
                end
            endcase
            r.outstanding = in_flight;
            r.ctl_depth   = control_cnt[6:0];
            r.nrm_depth   = normal_cnt[8:0];
            due_results.push_back(r);
        endfunction

        function void match(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(send_result_t got);
            send_result_t want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d handle %h",
                         $time, got.status, got.handle);
                errors++;
                return;
            end
            want = due_results.pop_front();
            match("status", want.status, got.status);
            match("out_handle", want.handle, got.handle);
            match("out_from_control", want.from_ctl, got.from_ctl);
            match("fairness_yield", want.yield_flag, got.yield_flag);
            match("canceled_count", want.canceled, got.canceled);
            match("outstanding_count", want.outstanding, got.outstanding);
            match("control_depth", want.ctl_depth, got.ctl_depth);
            match("normal_depth", want.nrm_depth, got.nrm_depth);
        endfunction
    endclass

    // clock, reset and every block input start at a known value
    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_we          = 1'b0;
    logic [3:0]  cfg_wdata       = '0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command       = CMD_SUBMIT;
    logic        s_slot_free     = 1'b0;
    logic [1:0]  s_priority_req  = PRIO_NORMAL;
    logic [15:0] s_packet_handle = '0;
    logic [7:0]  s_dest_length   = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_out_handle;
    logic        m_out_from_control;
    logic        m_fairness_yield;
    logic [8:0]  m_canceled_count;
    logic [15:0] m_outstanding_count;
    logic [6:0]  m_control_depth;
    logic [8:0]  m_normal_depth;

    // percent of cycles in which either side holds back
    int idle_pct = 36;

    arbiter_shadow shadow;

    two_lane_send_queue_burst_arbiter_unit DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_slot_free         (s_slot_free),
        .s_priority_req      (s_priority_req),
        .s_packet_handle     (s_packet_handle),
        .s_dest_length       (s_dest_length),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_out_handle        (m_out_handle),
        .m_out_from_control  (m_out_from_control),
        .m_fairness_yield    (m_fairness_yield),
        .m_canceled_count    (m_canceled_count),
        .m_outstanding_count (m_outstanding_count),
        .m_control_depth     (m_control_depth),
        .m_normal_depth      (m_normal_depth)
    );

    always #5 aclk = ~aclk;

    // result side: check what the block hands over, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            shadow.check_result('{status_t'(m_status), m_out_handle, m_out_from_control,
                                  m_fairness_yield, m_canceled_count, m_outstanding_count,
                                  m_control_depth, m_normal_depth});
        end
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // present one request and hold it until the block takes it
    task automatic push_request(command_t cmd, logic slot, logic [1:0] prio,
                                logic [15:0] handle, logic [7:0] dlen);
        // random gap, valid low
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_slot_free     <= slot;
        s_priority_req  <= prio;
        s_packet_handle <= handle;
        s_dest_length   <= dlen;
        do @(posedge aclk); while (!s_ready);
        shadow.note_request(cmd, slot, prio, handle, dlen);
    endtask

    // drop valid and wait until every due result is back, plus the pipeline depth
    task automatic settle();
        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // burst limit write, only while the block is idle
    task automatic write_burst_limit(logic [3:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        shadow.write_burst(value);
    endtask

    function automatic logic [7:0] good_len();
        return 8'($urandom_range(MAX_DEST_LEN, 1));
    endfunction

    // mostly well-formed traffic: queued submits and drains dominate so both
    // lanes fill and the burst limit comes into play; a few bad requests mixed in
    task automatic random_requests(int count);
        int         pick;
        command_t   cmd;
        logic [1:0] prio;
        logic [7:0] dlen;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45) cmd = CMD_SUBMIT;
            else if (pick < 80) cmd = CMD_DRAIN;
            else if (pick < 83) cmd = CMD_CANCEL;
            else cmd = CMD_COMPLETE;
            if ($urandom_range(99) < 8) prio = 2'($urandom_range(3, 2));
            else prio = 2'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 4) dlen = '0;
            else if (pick < 8) dlen = 8'($urandom_range(255, MAX_DEST_LEN + 1));
            else dlen = good_len();
            push_request(cmd, $urandom_range(99) < 25, prio, 16'($urandom), dlen);
        end
    endtask

    initial begin
        shadow = new();

        // reset held low from the start, then released for good
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed opening at the reset burst limit ---
        // completion and cancel with nothing outstanding must floor at zero
        push_request(CMD_COMPLETE, 1'b0, PRIO_NORMAL, 16'h0000, 8'd0);
        push_request(CMD_DRAIN, 1'b1, PRIO_BAD_HI, 16'hFFFF, 8'hFF);
        push_request(CMD_CANCEL, 1'b0, PRIO_NORMAL, 16'h0000, 8'd0);
        // rejected submits: bad priority, zero length, too long
        push_request(CMD_SUBMIT, 1'b0, PRIO_BAD_LO, 16'h1111, 8'd10);
        push_request(CMD_SUBMIT, 1'b1, PRIO_BAD_HI, 16'h2222, 8'd10);
        push_request(CMD_SUBMIT, 1'b1, PRIO_NORMAL, 16'h3333, 8'd0);
        push_request(CMD_SUBMIT, 1'b0, PRIO_CONTROL, 16'h4444, 8'd129);
        push_request(CMD_SUBMIT, 1'b0, PRIO_NORMAL, 16'h5555, 8'd255);
        // immediate sends at the length limits, both lanes
        push_request(CMD_SUBMIT, 1'b1, PRIO_NORMAL, 16'hFFFF, 8'd1);
        push_request(CMD_SUBMIT, 1'b1, PRIO_CONTROL, 16'h0000, MAX_DEST_LEN);
        // queue a few, then an immediate send overtakes them
        push_request(CMD_SUBMIT, 1'b0, PRIO_CONTROL, 16'h1234, MAX_DEST_LEN);
        push_request(CMD_SUBMIT, 1'b0, PRIO_NORMAL, 16'hABCD, 8'd64);
        push_request(CMD_SUBMIT, 1'b0, PRIO_CONTROL, 16'h00FF, 8'd1);
        push_request(CMD_SUBMIT, 1'b1, PRIO_CONTROL, 16'h8001, 8'd7);
        // drains: control first, then normal, then empty
        push_request(CMD_DRAIN, 1'b0, PRIO_NORMAL, 16'h0000, 8'd0);
        push_request(CMD_DRAIN, 1'b0, PRIO_NORMAL, 16'h0000, 8'd0);
        push_request(CMD_DRAIN, 1'b1, PRIO_CONTROL, 16'hFFFF, 8'd200);
        push_request(CMD_DRAIN, 1'b0, PRIO_NORMAL, 16'h0000, 8'd0);
        push_request(CMD_COMPLETE, 1'b1, PRIO_CONTROL, 16'hFFFF, 8'd1);
        // cancel with both lanes holding something
        push_request(CMD_SUBMIT, 1'b0, PRIO_NORMAL, 16'h5A5A, 8'd32);
        push_request(CMD_SUBMIT, 1'b0, PRIO_CONTROL, 16'hA5A5, 8'd96);
        push_request(CMD_CANCEL, 1'b1, PRIO_BAD_LO, 16'h7FFF, 8'd128);
        push_request(CMD_COMPLETE, 1'b0, PRIO_NORMAL, 16'h0000, 8'd0);
        settle();

        // --- burst limit 1: fill both lanes past full, no gaps anywhere ---
        write_burst_limit(4'd1);
        idle_pct = 0;
        repeat (CONTROL_DEPTH + 2)
            push_request(CMD_SUBMIT, 1'b0, PRIO_CONTROL, 16'($urandom), good_len());
        repeat (NORMAL_DEPTH + 2)
            push_request(CMD_SUBMIT, 1'b0, PRIO_NORMAL, 16'($urandom), good_len());
        // largest possible cancel count
        push_request(CMD_CANCEL, 1'b0, PRIO_NORMAL, 16'h0000, 8'd0);
        idle_pct = 36;
        // alternate lanes at burst limit 1: yields on every other drain until normal runs dry
        repeat (6) push_request(CMD_SUBMIT, 1'b0, PRIO_CONTROL, 16'($urandom), good_len());
        repeat (4) push_request(CMD_SUBMIT, 1'b0, PRIO_NORMAL, 16'($urandom), good_len());
        repeat (12) push_request(CMD_DRAIN, 1'b0, PRIO_NORMAL, 16'($urandom), 8'($urandom));
        settle();

        // --- widest burst limit ---
        write_burst_limit(4'd15);
        random_requests(35);
        settle();

        // --- zero burst limit: control only goes when normal is empty ---
        write_burst_limit(4'd0);
        random_requests(25);
        settle();

        // --- middle limit, with a full pause halfway through ---
        write_burst_limit(4'd3);
        random_requests(10);
        settle();
        random_requests(10);

        settle();
        if (shadow.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- two_lane_send_queue_burst_arbiter_unit.f -----
hdl/tlsqba_pkg.sv
hdl/tlsqba_ram.sv
hdl/tlsqba_ctrl.sv
hdl/tlsqba_dp.sv
hdl/two_lane_send_queue_burst_arbiter_unit.sv
hdl/tlsqba_chk.sv
tb/sv/tb.sv
